// ===== sv/tgad_pkg.sv =====
// Shared types and constants for the TGA run-length pixel decoder.
package tgad_pkg;

  localparam logic [1:0] CFG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [1:0] CFG_RUN_LENGTH_MODE = 2'd1;
  localparam logic [1:0] CFG_PIXEL_TOTAL     = 2'd2;

  localparam logic [6:0] HDR_COUNT_MASK = 7'h7F;
  localparam int unsigned HDR_RUN_BIT   = 7;

  typedef struct packed {
    logic [2:0]  bytes_per_pixel;
    logic        run_length_mode;
    logic [31:0] pixel_total;
  } cfg_t;

  typedef struct packed {
    logic        phase;
    logic        packet_is_run;
    logic [7:0]  pixels_left;
    logic [1:0]  comp_idx;
    logic [23:0] colour_hold;
    logic [31:0] pixels_done;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       image_last;
    logic       overrun;
  } pix_res_t;

endpackage

// ===== sv/tgad_step.sv =====
// Next-state and result logic for one stream byte of the TGA decoder.
module tgad_step import tgad_pkg::*; (
  input  cfg_t       cfg_i,
  input  dec_state_t state_i,
  input  logic [7:0] byte_i,
  output dec_state_t state_o,
  output logic       emit_o,
  output pix_res_t   res_o
);

  logic              is_hdr;
  logic [1:0]        last_comp;
  logic [3:0][7:0]   comp;
  logic [7:0]        req;
  logic [32:0]       diff;
  logic [31:0]       remaining;
  logic              rem_small;
  logic [7:0]        cnt;
  logic              over;
  logic              last;
  logic [7:0]        left_n;

  always_comb begin
    unique case (cfg_i.bytes_per_pixel)
      3'd0, 3'd1: last_comp = 2'd0;
      3'd2:       last_comp = 2'd1;
      3'd3:       last_comp = 2'd2;
      default:    last_comp = 2'd3;
    endcase
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (k < 3 && 2'(k) < state_i.comp_idx) begin
        comp[k] = state_i.colour_hold[8*(k%3) +: 8];
      end else begin
        comp[k] = 8'd0;
      end
    end
    comp[state_i.comp_idx] = byte_i;
  end

  always_comb begin
    if (cfg_i.run_length_mode && state_i.packet_is_run && state_i.pixels_left != 8'd0) begin
      req = state_i.pixels_left;
    end else begin
      req = 8'd1;
    end
    diff = {1'b0, cfg_i.pixel_total} - {1'b0, state_i.pixels_done};
    if (!diff[32] && diff[31:0] != 32'd0) begin
      remaining = diff[31:0];
    end else begin
      remaining = 32'd1;
    end
    rem_small = (remaining[31:8] == 24'd0);
    if (rem_small && req > remaining[7:0]) begin
      cnt  = remaining[7:0];
      over = 1'b1;
    end else begin
      cnt  = req;
      over = 1'b0;
    end
    last = rem_small && (cnt == remaining[7:0]);
  end

  always_comb begin
    is_hdr  = cfg_i.run_length_mode && !state_i.phase;
    state_o = state_i;
    emit_o  = 1'b0;
    res_o   = '0;
    left_n  = state_i.pixels_left;
    if (is_hdr) begin
      state_o.packet_is_run = byte_i[HDR_RUN_BIT];
      state_o.pixels_left   = {1'b0, byte_i[6:0] & HDR_COUNT_MASK} + 8'd1;
      state_o.phase         = 1'b1;
      state_o.comp_idx      = 2'd0;
      state_o.colour_hold   = 24'd0;
    end else if (state_i.comp_idx < last_comp) begin
      state_o.colour_hold[8*state_i.comp_idx[1:0] +: 8] = byte_i;
      state_o.comp_idx = state_i.comp_idx + 2'd1;
    end else begin
      emit_o = 1'b1;
      res_o.overrun = over;
      if (cfg_i.run_length_mode) begin
        if (state_i.packet_is_run) begin
          left_n = 8'd0;
        end else begin
          if (last && state_i.pixels_left > 8'd1) begin
            res_o.overrun = 1'b1;
          end
          if (state_i.pixels_left != 8'd0) begin
            left_n = state_i.pixels_left - 8'd1;
          end
        end
        if (left_n == 8'd0) begin
          state_o.phase = 1'b0;
        end
      end
      state_o.pixels_left = left_n;
      if (last) begin
        state_o.pixels_done = 32'd0;
        state_o.phase       = 1'b0;
        state_o.pixels_left = 8'd0;
      end else begin
        state_o.pixels_done = state_i.pixels_done + {24'd0, cnt};
      end
      state_o.comp_idx    = 2'd0;
      state_o.colour_hold = 24'd0;
      if (last_comp == 2'd0) begin
        res_o.red = comp[0];
      end else begin
        res_o.red   = comp[2];
        res_o.green = comp[1];
        res_o.blue  = comp[0];
        res_o.alpha = comp[3];
      end
      res_o.repeat_count = cnt;
      res_o.image_last   = last;
    end
  end

endmodule

// ===== sv/tga_rle_pixel_decoder.sv =====
// Top level of the TGA run-length pixel decoder: registers and handshakes.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_ready_o  stream_byte_i
// out      output     out_valid_o/out_ready_i red, green, blue, alpha, repeat_count,
//                                            image_last, overrun
// cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One byte is taken per cycle unless a stalled result holds the input register; a byte that
// completes a pixel shows its item through the input register, then the result register.
// The decode state updates in one pass of the step logic behind the input register.
// Reset clears the decode state and loads the register defaults.
// A stalled result holds the input register only when that byte would emit.
module tga_rle_pixel_decoder import tgad_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic [7:0]  repeat_count_o,
  output logic        image_last_o,
  output logic        overrun_o
);

  cfg_t       cfg_q;
  dec_state_t state_q, state_d;
  logic [7:0] byte_q;
  logic       byte_vld_q;
  logic       out_vld_q;
  pix_res_t   res_q, res_d;
  logic       emit;
  logic       advance;

  tgad_step u_step (
    .cfg_i   (cfg_q),
    .state_i (state_q),
    .byte_i  (byte_q),
    .state_o (state_d),
    .emit_o  (emit),
    .res_o   (res_d)
  );

  assign advance     = byte_vld_q && (!emit || !out_vld_q || out_ready_i);
  assign in_ready_o  = !byte_vld_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bytes_per_pixel <= 3'd3;
      cfg_q.run_length_mode <= 1'b1;
      cfg_q.pixel_total     <= 32'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_BYTES_PER_PIXEL: cfg_q.bytes_per_pixel <= cfg_data_i[2:0];
        CFG_RUN_LENGTH_MODE: cfg_q.run_length_mode <= cfg_data_i[0];
        CFG_PIXEL_TOTAL:     cfg_q.pixel_total     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= '0;
      byte_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (advance) begin
        state_q <= state_d;
      end
      if (in_valid_i && in_ready_o) begin
        byte_vld_q <= 1'b1;
      end else if (advance) begin
        byte_vld_q <= 1'b0;
      end
      if (advance && emit) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= stream_byte_i;
    end
    if (advance && emit) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign red_o          = res_q.red;
  assign green_o        = res_q.green;
  assign blue_o         = res_q.blue;
  assign alpha_o        = res_q.alpha;
  assign repeat_count_o = res_q.repeat_count;
  assign image_last_o   = res_q.image_last;
  assign overrun_o      = res_q.overrun;

`ifndef SYNTHESIS
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> res_q.repeat_count != 8'd0)
    else $error("Emitted item has a zero repeat count.");

  a_overrun_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.overrun |-> res_q.image_last)
    else $error("Overrun flagged on an item that does not end the image.");

  a_left_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.pixels_left <= 8'd128)
    else $error("Packet pixel count exceeds the header maximum.");

  a_held_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_vld_q && !advance |=> byte_vld_q && $stable(byte_q))
    else $error("Stalled input byte was lost or changed.");
`endif

endmodule

// ===== verif/tb_tga_rle_pixel_decoder.sv =====
// Self-checking testbench for the TGA run-length pixel decoder with its own pixel predictor.
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder;
  import tgad_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_CYCLES = 10;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_PHASES = 18;
  localparam int BYTES_PER_PHASE = 80;
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;

  typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [1:0] idx;
    logic [31:0] data;
    bit         typed;
    pix_res_t   px;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  stream_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_o;
  logic [7:0]  repeat_count_o;
  logic        image_last_o;
  logic        overrun_o;

  logic [2:0]  dec_bpp = 3'd3;
  logic        dec_rle = 1'b1;
  logic [31:0] dec_total = 32'd1;
  logic        dec_in_packet = 1'b0;
  logic        dec_is_run = 1'b0;
  logic [7:0]  dec_left = '0;
  logic [1:0]  dec_comp = '0;
  logic [23:0] dec_hold = '0;
  logic [31:0] dec_done = '0;

  pix_res_t pending_pixels[$];
  dir_row_t dir_rows[$];
  int pixel_errors = 0;
  int stall_cycles = 0;
  int send_idle = 28;
  int recv_idle = 68;

  tga_rle_pixel_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .stream_byte_i  (stream_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .alpha_o        (alpha_o),
    .repeat_count_o (repeat_count_o),
    .image_last_o   (image_last_o),
    .overrun_o      (overrun_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic bit decode_byte(input logic [7:0] b, output pix_res_t px);
    logic [2:0]  ncomp;
    logic [7:0]  part [4];
    logic [7:0]  req;
    logic [31:0] remaining;
    logic [31:0] cnt;
    logic        over;
    logic        last;
    int          k;
    px = '0;
    ncomp = (dec_bpp == 3'd0) ? 3'd1 : (dec_bpp > 3'd4) ? 3'd4 : dec_bpp;
    if (dec_rle && !dec_in_packet) begin
      dec_is_run = b[HDR_RUN_BIT];
      dec_left = {1'b0, b[6:0] & HDR_COUNT_MASK} + 8'd1;
      dec_in_packet = 1'b1;
      dec_comp = '0;
      dec_hold = '0;
      return 1'b0;
    end
    if ({1'b0, dec_comp} < ncomp - 3'd1) begin
      dec_hold = dec_hold | (24'(b) << (8 * dec_comp));
      dec_comp = dec_comp + 2'd1;
      return 1'b0;
    end
    for (k = 0; k < 4; k++) begin
      part[k] = '0;
    end
    for (k = 0; k < 3; k++) begin
      if (k < dec_comp) begin
        part[k] = dec_hold[8*k +: 8];
      end
    end
    part[dec_comp] = b;
    req = (dec_rle && dec_is_run) ? dec_left : 8'd1;
    if (req == 8'd0) begin
      req = 8'd1;
    end
    remaining = (dec_done < dec_total) ? dec_total - dec_done : 32'd1;
    over = 1'b0;
    if (32'(req) > remaining) begin
      cnt = remaining;
      over = 1'b1;
    end else begin
      cnt = 32'(req);
    end
    last = (cnt == remaining);
    if (dec_rle) begin
      if (dec_is_run) begin
        dec_left = '0;
      end else begin
        if (last && dec_left > 8'd1) begin
          over = 1'b1;
        end
        if (dec_left > 8'd0) begin
          dec_left = dec_left - 8'd1;
        end
      end
      if (dec_left == 8'd0) begin
        dec_in_packet = 1'b0;
      end
    end
    if (last) begin
      dec_done = '0;
      dec_in_packet = 1'b0;
      dec_left = '0;
    end else begin
      dec_done = dec_done + cnt;
    end
    dec_comp = '0;
    dec_hold = '0;
    if (ncomp == 3'd1) begin
      px.red = part[0];
    end else begin
      px.red = part[2];
      px.green = part[1];
      px.blue = part[0];
      px.alpha = part[3];
    end
    px.repeat_count = cnt[7:0];
    px.image_last = last;
    px.overrun = over;
    return 1'b1;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input pix_res_t typed_px);
    pix_res_t px;
    int gap;
    if (decode_byte(b, px)) begin
      pending_pixels.push_back(typed ? typed_px : px);
    end
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_BYTES_PER_PIXEL: dec_bpp = data[2:0];
      CFG_RUN_LENGTH_MODE: dec_rle = data[0];
      CFG_PIXEL_TOTAL:     dec_total = data;
      default: ;
    endcase
  endtask

  task automatic add_cfg(input logic [1:0] idx, input logic [31:0] data);
    dir_row_t row;
    row = '{ROW_CFG, idx, data, 1'b0, '0};
    dir_rows.push_back(row);
  endtask

  task automatic add_byte(input logic [7:0] b);
    dir_row_t row;
    row = '{ROW_BYTE, 2'd0, {24'd0, b}, 1'b0, '0};
    dir_rows.push_back(row);
  endtask

  task automatic add_pixel(input logic [7:0] b, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] bl, input logic [7:0] a, input logic [7:0] cnt,
                           input logic last, input logic over);
    dir_row_t row;
    row = '{ROW_BYTE, 2'd0, {24'd0, b}, 1'b1, '{r, g, bl, a, cnt, last, over}};
    dir_rows.push_back(row);
  endtask

  always @(posedge clk_i) begin
    pix_res_t got;
    pix_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {red_o, green_o, blue_o, alpha_o, repeat_count_o, image_last_o, overrun_o};
      if (pending_pixels.size() == 0) begin
        pixel_errors++;
        if (pixel_errors <= 10) begin
          $display("Unexpected pixel: r%h g%h b%h a%h n%0d last%b ovr%b",
                   got.red, got.green, got.blue, got.alpha, got.repeat_count,
                   got.image_last, got.overrun);
        end
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.alpha !== want.alpha || got.repeat_count !== want.repeat_count ||
            got.image_last !== want.image_last || got.overrun !== want.overrun) begin
          pixel_errors++;
          if (pixel_errors <= 10) begin
            $display("Pixel mismatch: expected r%h g%h b%h a%h n%0d last%b ovr%b",
                     want.red, want.green, want.blue, want.alpha, want.repeat_count,
                     want.image_last, want.overrun);
            $display("                got      r%h g%h b%h a%h n%0d last%b ovr%b",
                     got.red, got.green, got.blue, got.alpha, got.repeat_count,
                     got.image_last, got.overrun);
          end
        end
      end
    end
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    dir_row_t    row;
    logic [7:0]  b;
    logic [2:0]  bpp;
    logic        rle;
    logic [31:0] tot;

    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_pixel(8'h80, 8'h80, 8'hFF, 8'h00, 8'h00, 8'd1, 1'b1, 1'b1);
    add_cfg(CFG_PIXEL_TOTAL, 32'hFFFF_FFFF);
    add_cfg(CFG_BYTES_PER_PIXEL, 32'd4);
    add_byte(8'h85);
    add_byte(8'h01);
    add_byte(8'h02);
    add_byte(8'h03);
    add_pixel(8'h04, 8'h03, 8'h02, 8'h01, 8'h04, 8'd6, 1'b0, 1'b0);
    add_cfg(CFG_BYTES_PER_PIXEL, 32'hFFFF_FFFA);
    add_byte(8'h82);
    add_byte(8'h12);
    add_pixel(8'h34, 8'h00, 8'h34, 8'h12, 8'h00, 8'd3, 1'b0, 1'b0);
    add_cfg(CFG_BYTES_PER_PIXEL, 32'd0);
    add_byte(8'h80);
    add_byte(8'h5A);
    add_cfg(CFG_BYTES_PER_PIXEL, 32'd6);
    add_byte(8'h80);
    add_byte(8'h0F);
    add_byte(8'h1E);
    add_byte(8'h2D);
    add_byte(8'h3C);
    add_cfg(CFG_BYTES_PER_PIXEL, 32'd4);
    add_byte(8'h80);
    add_byte(8'hA1);
    add_byte(8'hB2);
    add_cfg(CFG_BYTES_PER_PIXEL, 32'd1);
    add_byte(8'hC3);
    add_byte(8'h02);
    add_byte(8'h10);
    add_cfg(CFG_RUN_LENGTH_MODE, 32'd0);
    add_byte(8'h20);
    add_cfg(CFG_RUN_LENGTH_MODE, 32'hFFFF_FFFF);
    add_byte(8'h30);
    add_byte(8'h40);
    add_cfg(CFG_UNUSED_IDX, 32'hA5A5_5A5A);
    add_cfg(CFG_PIXEL_TOTAL, 32'd0);
    add_byte(8'h80);
    add_byte(8'h99);
    add_cfg(CFG_PIXEL_TOTAL, 32'd2);
    add_byte(8'h03);
    add_byte(8'h01);
    add_pixel(8'h02, 8'h02, 8'h00, 8'h00, 8'h00, 8'd1, 1'b1, 1'b1);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.idx, row.data);
      end else begin
        send_byte(row.data[7:0], row.typed, row.px);
      end
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < RANDOM_PHASES / 3) begin
        send_idle = 28;
        recv_idle = 68;
      end else if (p < 2 * RANDOM_PHASES / 3) begin
        send_idle = 68;
        recv_idle = 28;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      case ($urandom_range(0, 5))
        0: bpp = 3'd1;
        1: bpp = 3'd4;
        2: bpp = 3'd2;
        3: bpp = 3'($urandom_range(0, 7));
        default: bpp = 3'd3;
      endcase
      rle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: tot = 32'hFFFF_FFFF;
        1: tot = 32'd0;
        2: tot = $urandom;
        default: tot = $urandom_range(1, 40);
      endcase
      if (p == 0) begin
        bpp = 3'd4;
        tot = 32'hFFFF_FFFF;
      end else if (p == 1) begin
        bpp = 3'd1;
        tot = 32'd1;
      end
      write_reg(CFG_BYTES_PER_PIXEL, ($urandom & 32'hFFFF_FFF8) | 32'(bpp));
      write_reg(CFG_RUN_LENGTH_MODE, ($urandom & 32'hFFFF_FFFE) | 32'(rle));
      write_reg(CFG_PIXEL_TOTAL, tot);
      for (int n = 0; n < BYTES_PER_PHASE; n++) begin
        if (n == BYTES_PER_PHASE / 2 && p % 4 == 1) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (pending_pixels.size() != 0);
        end
        if (dec_rle && !dec_in_packet && $urandom_range(0, 9) != 0) begin
          b[7] = 1'($urandom_range(0, 1));
          b[6:0] = ($urandom_range(0, 9) < 8) ? 7'($urandom_range(0, 7))
                                               : 7'($urandom_range(0, 127));
        end else begin
          b = 8'($urandom_range(0, 255));
        end
        send_byte(b, 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pixel_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
